[hw/rtl/plir_pkg.sv]
// Shared types and constants for the positional list block.
// Used by plir_ctrl, plir_dp and positional_list_insert_remove; no dependencies.
package plir_pkg;

  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INS_FIRST,
    CMD_INS_MOVE,
    CMD_INS_PUT,
    CMD_RM_FIRST,
    CMD_RM_GRAB,
    CMD_RM_MOVE,
    CMD_RESULT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    status_t res_status;
  } dp_ctrl_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic ins_shift;
    logic ins_more;
    logic rm_more;
    logic out_busy;
  } dp_stat_t;

endpackage

[hw/rtl/plir_ctrl.sv]
// Sequencer for the positional list: steps each transaction through the shift.
// Depends on plir_pkg; drives plir_dp through a command struct.
module plir_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  plir_pkg::dp_stat_t stat,
  output plir_pkg::dp_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_MV,
    S_INS_PUT,
    S_RM_GRAB,
    S_RM_MV,
    S_FIN
  } state_t;

  state_t             state;
  state_t             state_next;
  plir_pkg::status_t  res_status;
  plir_pkg::status_t  res_status_next;
  plir_pkg::dp_cmd_t  cmd;

  assign in_stall        = (state != S_IDLE) || rst;
  assign ctrl.cmd        = cmd;
  assign ctrl.res_status = res_status;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = plir_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = plir_pkg::CMD_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        res_status_next = plir_pkg::ST_OK;
        if (!stat.is_remove) begin
          if (stat.full) begin
            res_status_next = plir_pkg::ST_FULL;
            state_next      = S_FIN;
          end else if (stat.ins_shift) begin
            cmd        = plir_pkg::CMD_INS_FIRST;
            state_next = S_INS_MV;
          end else begin
            state_next = S_INS_PUT;
          end
        end else begin
          if (stat.empty) begin
            res_status_next = plir_pkg::ST_EMPTY;
            state_next      = S_FIN;
          end else begin
            cmd        = plir_pkg::CMD_RM_FIRST;
            state_next = S_RM_GRAB;
          end
        end
      end
      S_INS_MV: begin
        cmd = plir_pkg::CMD_INS_MOVE;
        if (!stat.ins_more) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd        = plir_pkg::CMD_INS_PUT;
        state_next = S_FIN;
      end
      S_RM_GRAB: begin
        cmd        = plir_pkg::CMD_RM_GRAB;
        state_next = stat.rm_more ? S_RM_MV : S_FIN;
      end
      S_RM_MV: begin
        cmd = plir_pkg::CMD_RM_MOVE;
        if (!stat.rm_more) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd        = plir_pkg::CMD_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= plir_pkg::ST_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

[hw/rtl/plir_dp.sv]
// Datapath for the positional list: element memory, count, pointers, result register.
// Depends on plir_pkg; commanded by plir_ctrl.
module plir_dp #(
  parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  plir_pkg::dp_ctrl_t  ctrl,
  output plir_pkg::dp_stat_t  stat,
  input  logic                op,
  input  logic [15:0]         position,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  removed_value,
  output logic [1:0]          status,
  output logic [6:0]          element_count,
  output logic                is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]    mem [CAPACITY];
  logic [31:0]    rdata;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_new;
  logic [CW-1:0]  ptr;
  logic [CW-1:0]  at;
  logic           op_hold;
  logic [31:0]    value_hold;
  logic [31:0]    removed_hold;

  logic           we;
  logic [CW-1:0]  waddr;
  logic [31:0]    wdata;
  logic           re;
  logic [CW-1:0]  raddr;
  logic [CW-1:0]  ptr_next;

  logic [15:0]    idx;
  logic [CW-1:0]  limit;
  logic [CW-1:0]  at_load;
  logic [CW+6:0]  count_wide;

  assign idx     = (position == 16'd0) ? 16'd0 : position - 16'd1;
  assign limit   = op ? count - CW'(1) : count;
  assign at_load = (idx > 16'(limit)) ? limit : idx[CW-1:0];

  assign stat.is_remove = op_hold;
  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.empty     = (count == '0);
  assign stat.ins_shift = (count > at);
  assign stat.ins_more  = (ptr > at);
  assign stat.rm_more   = ((ptr + CW'(1)) < count);
  assign stat.out_busy  = out_valid && out_stall;

  always_comb begin
    we       = 1'b0;
    waddr    = ptr;
    wdata    = rdata;
    re       = 1'b0;
    raddr    = ptr;
    ptr_next = ptr;
    case (ctrl.cmd)
      plir_pkg::CMD_INS_FIRST: begin
        re       = 1'b1;
        raddr    = count - CW'(1);
        ptr_next = count - CW'(1);
      end
      plir_pkg::CMD_INS_MOVE: begin
        we    = 1'b1;
        waddr = ptr + CW'(1);
        if (stat.ins_more) begin
          re       = 1'b1;
          raddr    = ptr - CW'(1);
          ptr_next = ptr - CW'(1);
        end
      end
      plir_pkg::CMD_INS_PUT: begin
        we    = 1'b1;
        waddr = at;
        wdata = value_hold;
      end
      plir_pkg::CMD_RM_FIRST: begin
        re       = 1'b1;
        raddr    = at;
        ptr_next = at;
      end
      plir_pkg::CMD_RM_GRAB: begin
        if (stat.rm_more) begin
          re       = 1'b1;
          raddr    = ptr + CW'(1);
          ptr_next = ptr + CW'(1);
        end
      end
      plir_pkg::CMD_RM_MOVE: begin
        we    = 1'b1;
        waddr = ptr - CW'(1);
        if (stat.rm_more) begin
          re       = 1'b1;
          raddr    = ptr + CW'(1);
          ptr_next = ptr + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

  always_comb begin
    count_new = count;
    if (ctrl.res_status == plir_pkg::ST_OK) begin
      count_new = op_hold ? count - CW'(1) : count + CW'(1);
    end
  end

  assign count_wide = {7'd0, count_new};

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (ctrl.cmd == plir_pkg::CMD_LOAD) begin
      op_hold      <= op;
      value_hold   <= value;
      at           <= at_load;
      removed_hold <= '0;
    end
    if (ctrl.cmd == plir_pkg::CMD_RM_GRAB) begin
      removed_hold <= rdata;
    end
    if (ctrl.cmd == plir_pkg::CMD_RESULT) begin
      removed_value <= removed_hold;
      status        <= ctrl.res_status;
      element_count <= count_wide[6:0];
      is_empty      <= (count_new == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.cmd == plir_pkg::CMD_RESULT) begin
        count     <= count_new;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/positional_list_insert_remove.sv]
// Ordered list of up to CAPACITY signed words, insert or remove at a 1-based position.
// Top level; depends on plir_pkg, plir_ctrl and plir_dp.
//
// Each transaction takes one word in or out at a position (0 acts as the head, a position
// past the count means the tail) and gives one result. Transactions are handled one at a
// time. The elements live in a memory with one read and one write port that moves one word
// per cycle, so an insert or remove that lands further before the tail takes longer, and
// an insert into a full list or a remove from an empty one skips the shift and goes straight
// to its result. A new transaction is taken as soon as the previous result has been loaded
// into the output register, even while that result waits.
module positional_list_insert_remove #(
  parameter int CAPACITY = plir_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [15:0]        position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] removed_value,
  output logic [1:0]         status,
  output logic [6:0]         element_count,
  output logic               is_empty
);

  plir_pkg::dp_ctrl_t ctrl;
  plir_pkg::dp_stat_t stat;

  plir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  plir_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .op            (op),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .removed_value (removed_value),
    .status        (status),
    .element_count (element_count),
    .is_empty      (is_empty)
  );

endmodule
